// ===== rtl/esd_pkg.sv =====
`default_nettype none

package esd_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;

    // Decode mode, one-hot.
    typedef enum logic [3:0] {
        MODE_PLAIN = 4'b0001,
        MODE_ESC   = 4'b0010,
        MODE_HEX1  = 4'b0100,
        MODE_HEX2  = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       end_mark;
        logic [7:0] byte_total;
    } result_t;

    // Hex digit value of a character; anything that is not a hex digit counts as 0.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            n = c[3:0] + 4'd9;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/esd_in_stage.sv =====
`default_nettype none

module esd_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire esd_pkg::item_t in_item,
    input  wire logic          take,
    output logic               item_valid,
    output esd_pkg::item_t     item
);

    logic            valid_reg;
    esd_pkg::item_t  item_reg;

    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/esd_decode.sv =====
`default_nettype none

module esd_decode (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire esd_pkg::item_t  item,
    input  wire logic            slot_free,
    output logic                 take,
    output logic                 res_valid,
    output esd_pkg::result_t     res
);

    esd_pkg::mode_t mode_reg, mode_next, mode_step;
    logic [3:0]     nib_reg, nib_next, nib_step;
    logic [7:0]     count_reg, count_next, count_step;
    logic           emit;
    logic [7:0]     byte_val;
    logic           produce;

    always_comb
    begin
        mode_step = mode_reg;
        nib_step  = nib_reg;
        emit      = 1'b0;
        byte_val  = 8'd0;
        unique case (mode_reg)
            esd_pkg::MODE_PLAIN:
            begin
                if (item.ch == esd_pkg::CH_BACKSLASH)
                begin
                    mode_step = esd_pkg::MODE_ESC;
                end
                else
                begin
                    emit     = 1'b1;
                    byte_val = item.ch;
                end
            end
            esd_pkg::MODE_ESC:
            begin
                if (item.ch == esd_pkg::CH_BACKSLASH)
                begin
                    emit      = 1'b1;
                    byte_val  = esd_pkg::CH_BACKSLASH;
                    mode_step = esd_pkg::MODE_PLAIN;
                end
                else if (item.ch == esd_pkg::CH_LOWER_X)
                begin
                    mode_step = esd_pkg::MODE_HEX1;
                    emit      = item.last;
                end
                else
                begin
                    mode_step = esd_pkg::MODE_PLAIN;
                end
            end
            esd_pkg::MODE_HEX1:
            begin
                nib_step  = esd_pkg::nibble_of(item.ch);
                mode_step = esd_pkg::MODE_HEX2;
                emit      = item.last;
                byte_val  = {esd_pkg::nibble_of(item.ch), 4'd0};
            end
            esd_pkg::MODE_HEX2:
            begin
                emit      = 1'b1;
                byte_val  = {nib_reg, esd_pkg::nibble_of(item.ch)};
                mode_step = esd_pkg::MODE_PLAIN;
            end
            default:
            begin
                mode_step = esd_pkg::MODE_PLAIN;
            end
        endcase

        count_step = count_reg;
        if (emit && count_reg != 8'hFF)
        begin
            count_step = count_reg + 8'd1;
        end

        produce = emit || item.last;
        take    = item_valid && (!produce || slot_free);
        res_valid = item_valid && produce && slot_free;

        res.data_byte  = emit ? byte_val : 8'd0;
        res.has_data   = emit;
        res.end_mark   = item.last;
        res.byte_total = count_step;

        // The end of a string returns all decode state to its starting point.
        if (item.last)
        begin
            mode_next  = esd_pkg::MODE_PLAIN;
            nib_next   = 4'd0;
            count_next = 8'd0;
        end
        else
        begin
            mode_next  = mode_step;
            nib_next   = nib_step;
            count_next = count_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= esd_pkg::MODE_PLAIN;
            nib_reg   <= 4'd0;
            count_reg <= 8'd0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            nib_reg   <= nib_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/esd_out_stage.sv =====
`default_nettype none

module esd_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire esd_pkg::result_t res,
    output logic                  slot_free,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output esd_pkg::result_t      out_res
);

    logic             valid_reg;
    esd_pkg::result_t res_reg;

    assign slot_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/escape_sequence_decoder.sv =====
// A request accepted into the input register shows its result at out_valid once the result
// register loads it; that load waits as long as the result slot is full.
// Throughput: one character per cycle unless a result waits on a full slot; a character
// with no result (a backslash, the x of a hex escape, the first hex digit) only updates the
// decode state. The input and result registers each stall only when the result slot is full.
// Reset: rst_n is asynchronous and active low; it empties both registers and clears the
// decode mode, the pending high nibble and the byte count.
`default_nettype none

module escape_sequence_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] ch,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      data_byte,
    output logic            has_data,
    output logic            end_mark,
    output logic [7:0]      byte_total
);

    esd_pkg::item_t   in_item;
    esd_pkg::item_t   item;
    esd_pkg::result_t res;
    esd_pkg::result_t out_res;
    logic             item_valid;
    logic             take;
    logic             res_valid;
    logic             slot_free;

    assign in_item.ch   = ch;
    assign in_item.last = last;

    // The input register holds one request while the decoder waits for a free result slot.
    esd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // The decoder holds the mode, the high nibble and the count. A request that yields
    // no result is consumed at once, even while the result slot is full.
    esd_decode u_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .slot_free  (slot_free),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    // The result register frees up in the same cycle that its result is taken.
    esd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign data_byte  = out_res.data_byte;
    assign has_data   = out_res.has_data;
    assign end_mark   = out_res.end_mark;
    assign byte_total = out_res.byte_total;

endmodule

`default_nettype wire

// ===== rtl/esd_checker.sv =====
`default_nettype none

module esd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [7:0] ch,
    input wire logic       last,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] data_byte,
    input wire logic       has_data,
    input wire logic       end_mark,
    input wire logic [7:0] byte_total
);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(has_data)
            && $stable(end_mark) && $stable(byte_total))
        else $error("result changed while stalled");

    // A result without a byte exists only to mark the end of a string.
    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_data |-> end_mark && data_byte == 8'd0)
        else $error("empty result without end mark");

    // A result that carries a byte counts at least that byte.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_data |-> byte_total != 8'd0)
        else $error("byte count is zero on a data result");

    // Nothing comes out right after reset, since both registers start empty.
    a_quiet_after_reset: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (.*);

`default_nettype wire
